// ===== design/asd_pkg.sv =====
package asd_pkg;

  // axis sample width and derived widths
  localparam int AXIS_BITS   = 10;
  localparam int SUM_BITS    = 2 * AXIS_BITS + 2;
  localparam int ROOT_BITS   = AXIS_BITS + 1;
  localparam int REM_BITS    = ROOT_BITS + 2;
  localparam int MAG_BITS    = 11;
  localparam int HI_BITS     = MAG_BITS + 2;
  localparam int W_BITS      = 10;
  localparam int SETTLE_BITS = 8;
  localparam int MARGIN_BITS = 10;
  localparam int STEP_BITS   = 32;
  localparam int CNT_BITS    = $clog2(ROOT_BITS + 1);

  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 10;

  localparam logic [MAG_BITS-1:0]    MAG_MAX        = 11'd2047;
  localparam logic [MAG_BITS-1:0]    PEAK_LOW_RESET = 11'd1024;
  localparam logic [W_BITS-1:0]      WEIGHT_RESET   = 10'd128;
  localparam logic [SETTLE_BITS-1:0] SETTLE_RESET   = 8'd5;
  localparam logic [SETTLE_BITS-1:0] SETTLE_SAT     = 8'd255;
  localparam logic [MARGIN_BITS-1:0] MARGIN_RESET   = 10'd25;

  // register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_WEIGHT = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_SETTLE = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_MARGIN = 2'd2;

  typedef enum logic [1:0] {
    PH_MAX  = 2'd0,
    PH_FALL = 2'd1,
    PH_MIN  = 2'd2,
    PH_RISE = 2'd3
  } phase_t;

endpackage

// ===== design/asd_if.sv =====
interface asd_sample_if;
  logic                          valid;
  logic                          ready;
  logic [asd_pkg::AXIS_BITS-1:0] accel_x;
  logic [asd_pkg::AXIS_BITS-1:0] accel_y;
  logic [asd_pkg::AXIS_BITS-1:0] accel_z;

  modport source (output valid, output accel_x, output accel_y, output accel_z, input ready);
  modport sink   (input valid, input accel_x, input accel_y, input accel_z, output ready);
endinterface

interface asd_result_if;
  logic                          valid;
  logic                          ready;
  logic [asd_pkg::MAG_BITS-1:0]  magnitude;
  logic [asd_pkg::MAG_BITS-1:0]  average;
  logic [asd_pkg::STEP_BITS-1:0] step_total;
  logic                          step_seen;
  logic [1:0]                    detector_phase;

  modport source (output valid, output magnitude, output average, output step_total,
                  output step_seen, output detector_phase, input ready);
  modport sink   (input valid, input magnitude, input average, input step_total,
                  input step_seen, input detector_phase, output ready);
endinterface

interface asd_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [asd_pkg::CFG_IDX_BITS-1:0]  index;
  logic [asd_pkg::CFG_DATA_BITS-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== design/accel_step_detector.sv =====
// Step detector for a three-axis accelerometer. Each sample item yields exactly one
// result item: the floor square root of x*x + y*y + z*z (saturated at 2047), the
// exponential average of that magnitude after the sample, the running step total,
// a flag for a completed crossing and the detector phase. Work is bit-serial: the
// sum of squares takes one multiplier bit per cycle, the square root one root bit
// per cycle, the average blend one weight bit per cycle (skipped for the first
// sample after reset, which only seeds the average), then the detector update and
// the return to idle; the update waits while a stalled result holds the result
// register. One item is worked on at a time; the result register lets the next
// sample in while the last result still waits. Configuration writes are always
// ready; write them only while no item is in flight.
module accel_step_detector (
  input  logic         clk,
  input  logic         rst,
  asd_sample_if.sink   samples,
  asd_result_if.source results,
  asd_cfg_if.sink      cfg
);
  import asd_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SQR    = 5'b00010,
    S_ROOT   = 5'b00100,
    S_BLEND  = 5'b01000,
    S_UPDATE = 5'b10000
  } fsm_t;

  localparam int RW = (ROOT_BITS > MAG_BITS) ? ROOT_BITS : MAG_BITS;

  fsm_t state;
  logic [CNT_BITS-1:0] cnt;

  // configuration registers
  logic [W_BITS-1:0]      smoothing_weight;
  logic [SETTLE_BITS-1:0] settle_samples;
  logic [MARGIN_BITS-1:0] crossing_margin;

  // detector state
  logic                   seeded;
  logic [MAG_BITS-1:0]    avg_value;
  logic [MAG_BITS-1:0]    peak_high;
  logic [MAG_BITS-1:0]    peak_low;
  logic [SETTLE_BITS-1:0] settle_count;
  phase_t                 phase;
  logic [STEP_BITS-1:0]   step_counter;

  // serial datapath
  logic [SUM_BITS-1:0]  xm, ym, zm;   // multiplicands, shifted left
  logic [AXIS_BITS-1:0] xs, ys, zs;   // multiplier bits, shifted right
  logic [SUM_BITS-1:0]  sum;
  logic [REM_BITS-1:0]  rem;
  logic [ROOT_BITS-1:0] root;
  logic [W_BITS-1:0]    wb, wcb;
  logic [HI_BITS-1:0]   hi;

  // result register
  logic                 out_valid;
  logic [MAG_BITS-1:0]  o_mag, o_avg;
  logic [STEP_BITS-1:0] o_total;
  logic                 o_seen;
  phase_t               o_phase;

  logic in_acc;
  assign samples.ready = (state == S_IDLE);
  assign in_acc        = samples.valid && samples.ready;
  assign cfg.ready     = 1'b1;

  assign results.valid          = out_valid;
  assign results.magnitude      = o_mag;
  assign results.average        = o_avg;
  assign results.step_total     = o_total;
  assign results.step_seen      = o_seen;
  assign results.detector_phase = o_phase;

  // one partial product row per cycle
  logic [SUM_BITS-1:0] sqr_add;
  assign sqr_add = (xs[0] ? xm : '0) + (ys[0] ? ym : '0) + (zs[0] ? zm : '0);

  // restoring square root, one root bit per cycle
  logic [REM_BITS-1:0] rem_sh, trial;
  logic                root_ge;
  assign rem_sh  = {rem[REM_BITS-3:0], sum[SUM_BITS-1 -: 2]};
  assign trial   = {root, 2'b01};
  assign root_ge = (rem_sh >= trial);

  // magnitude, saturated to eleven bits
  logic [RW-1:0]       root_ext;
  logic [MAG_BITS-1:0] mag;
  assign root_ext = RW'(root);
  assign mag      = (root_ext > RW'(MAG_MAX)) ? MAG_MAX : root_ext[MAG_BITS-1:0];

  // lsb-first blend: hi tracks floor(partial product / 2^i)
  logic [HI_BITS-1:0] hi_sum;
  assign hi_sum = hi + (wb[0] ? HI_BITS'(mag) : '0) + (wcb[0] ? HI_BITS'(avg_value) : '0);

  // detector update
  logic [MAG_BITS-1:0]    avg_n;
  logic [MAG_BITS:0]      mag_plus, avg_plus;
  logic [SETTLE_BITS-1:0] settle_inc;
  logic                   settled;
  logic [MAG_BITS-1:0]    peak_high_n, peak_low_n;
  logic [SETTLE_BITS-1:0] settle_n;
  phase_t                 phase_n;
  logic                   seen_n;
  logic                   upd_fire;

  assign avg_n      = seeded ? hi[MAG_BITS-1:0] : mag;
  // mag < avg - margin rewritten without a signed difference
  assign mag_plus   = {1'b0, mag} + (MAG_BITS+1)'(crossing_margin);
  assign avg_plus   = {1'b0, avg_n} + (MAG_BITS+1)'(crossing_margin);
  assign settle_inc = (settle_count == SETTLE_SAT) ? SETTLE_SAT : settle_count + 1'b1;
  assign settled    = (settle_inc >= settle_samples);
  assign upd_fire   = (state == S_UPDATE) && (!out_valid || results.ready);

  always_comb begin
    peak_high_n = peak_high;
    peak_low_n  = peak_low;
    settle_n    = settle_count;
    phase_n     = phase;
    seen_n      = 1'b0;
    if (seeded) begin
      case (phase)
        PH_MAX: begin
          if (mag > peak_high) begin
            peak_high_n = mag;
            settle_n    = '0;
          end else begin
            settle_n = settle_inc;
            if (settled) phase_n = PH_FALL;
          end
        end
        PH_FALL: begin
          if (mag > peak_high) begin
            peak_high_n = mag;
            settle_n    = '0;
            phase_n     = PH_MAX;
          end else if (mag_plus < {1'b0, avg_n}) begin
            seen_n     = 1'b1;
            peak_low_n = PEAK_LOW_RESET;
            settle_n   = '0;
            phase_n    = PH_MIN;
          end
        end
        PH_MIN: begin
          if (mag < peak_low) begin
            peak_low_n = mag;
            settle_n   = '0;
          end else begin
            settle_n = settle_inc;
            if (settled) phase_n = PH_RISE;
          end
        end
        PH_RISE: begin
          if (mag < peak_low) begin
            peak_low_n = mag;
            settle_n   = '0;
            phase_n    = PH_MIN;
          end else if ({1'b0, mag} > avg_plus) begin
            seen_n      = 1'b1;
            peak_high_n = '0;
            settle_n    = '0;
            phase_n     = PH_MAX;
          end
        end
        default: phase_n = PH_MAX;
      endcase
    end
  end

  // sequencer and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      cnt              <= '0;
      out_valid        <= 1'b0;
      smoothing_weight <= WEIGHT_RESET;
      settle_samples   <= SETTLE_RESET;
      crossing_margin  <= MARGIN_RESET;
      seeded           <= 1'b0;
      avg_value        <= '0;
      peak_high        <= '0;
      peak_low         <= PEAK_LOW_RESET;
      settle_count     <= '0;
      phase            <= PH_MAX;
      step_counter     <= '0;
    end else begin
      if (cfg.valid) begin
        case (cfg.index)
          REG_WEIGHT: smoothing_weight <= cfg.data[W_BITS-1:0];
          REG_SETTLE: settle_samples   <= cfg.data[SETTLE_BITS-1:0];
          REG_MARGIN: crossing_margin  <= cfg.data[MARGIN_BITS-1:0];
          default: ;
        endcase
      end

      if (out_valid && results.ready && !upd_fire) out_valid <= 1'b0;

      case (state)
        S_IDLE: begin
          if (in_acc) begin
            state <= S_SQR;
            cnt   <= '0;
          end
        end
        S_SQR: begin
          if (cnt == CNT_BITS'(AXIS_BITS - 1)) begin
            state <= S_ROOT;
            cnt   <= '0;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_ROOT: begin
          if (cnt == CNT_BITS'(ROOT_BITS - 1)) begin
            state <= seeded ? S_BLEND : S_UPDATE;
            cnt   <= '0;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_BLEND: begin
          if (cnt == CNT_BITS'(W_BITS - 1)) begin
            state <= S_UPDATE;
            cnt   <= '0;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_UPDATE: begin
          if (upd_fire) begin
            state        <= S_IDLE;
            out_valid    <= 1'b1;
            seeded       <= 1'b1;
            avg_value    <= avg_n;
            peak_high    <= peak_high_n;
            peak_low     <= peak_low_n;
            settle_count <= settle_n;
            phase        <= phase_n;
            if (seen_n) step_counter <= step_counter + 1'b1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // serial datapath, no reset needed
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_acc) begin
          xm   <= SUM_BITS'(samples.accel_x);
          ym   <= SUM_BITS'(samples.accel_y);
          zm   <= SUM_BITS'(samples.accel_z);
          xs   <= samples.accel_x;
          ys   <= samples.accel_y;
          zs   <= samples.accel_z;
          sum  <= '0;
          rem  <= '0;
          root <= '0;
          hi   <= '0;
          wb   <= smoothing_weight;
          wcb  <= ~smoothing_weight;   // 1023 - weight
        end
      end
      S_SQR: begin
        sum <= sum + sqr_add;
        xm  <= {xm[SUM_BITS-2:0], 1'b0};
        ym  <= {ym[SUM_BITS-2:0], 1'b0};
        zm  <= {zm[SUM_BITS-2:0], 1'b0};
        xs  <= {1'b0, xs[AXIS_BITS-1:1]};
        ys  <= {1'b0, ys[AXIS_BITS-1:1]};
        zs  <= {1'b0, zs[AXIS_BITS-1:1]};
      end
      S_ROOT: begin
        sum  <= {sum[SUM_BITS-3:0], 2'b00};
        rem  <= root_ge ? (rem_sh - trial) : rem_sh;
        root <= {root[ROOT_BITS-2:0], root_ge};
      end
      S_BLEND: begin
        hi  <= {1'b0, hi_sum[HI_BITS-1:1]};
        wb  <= {1'b0, wb[W_BITS-1:1]};
        wcb <= {1'b0, wcb[W_BITS-1:1]};
      end
      S_UPDATE: begin
        if (upd_fire) begin
          o_mag   <= mag;
          o_avg   <= avg_n;
          o_total <= seen_n ? step_counter + 1'b1 : step_counter;
          o_seen  <= seen_n;
          o_phase <= phase_n;
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== design/asd_checker.sv =====
module asd_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [asd_pkg::MAG_BITS-1:0]  magnitude,
  input logic [asd_pkg::MAG_BITS-1:0]  average,
  input logic [asd_pkg::STEP_BITS-1:0] step_total,
  input logic                          step_seen,
  input logic [1:0]                    detector_phase
);
  import asd_pkg::*;

  // one item at a time: an accepted sample closes the input
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("sample accepted while an item is in flight");

  // a stalled result holds
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(magnitude) && $stable(average)
      && $stable(step_total) && $stable(step_seen) && $stable(detector_phase)))
    else $error("stalled result changed");

  // a crossing always lands in a search phase
  a_seen_phase: assert property (@(posedge clk) disable iff (rst)
    (out_valid && step_seen) |->
      (detector_phase == PH_MIN || detector_phase == PH_MAX))
    else $error("step reported outside a search phase");

  // a crossing result carries a step total that moved
  a_seen_total: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && !step_seen) ##1 (out_valid && step_seen) |->
      (step_total != $past(step_total)))
    else $error("step reported without a new total");

endmodule

bind accel_step_detector asd_checker u_asd_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (samples.valid),
  .in_ready       (samples.ready),
  .out_valid      (results.valid),
  .out_ready      (results.ready),
  .magnitude      (results.magnitude),
  .average        (results.average),
  .step_total     (results.step_total),
  .step_seen      (results.step_seen),
  .detector_phase (results.detector_phase)
);

// ===== bench/step_predict_check.sv =====
`timescale 1ns / 1ps

module step_predict_check (
  input  logic  clk,
  input  logic  rst,
  asd_sample_if samples,
  asd_result_if results,
  asd_cfg_if    cfg,
  output int    fails,
  output int    pending
);
  import asd_pkg::*;

  typedef struct packed {
    logic [MAG_BITS-1:0]  magnitude;
    logic [MAG_BITS-1:0]  average;
    logic [STEP_BITS-1:0] step_total;
    logic                 step_seen;
    logic [1:0]           detector_phase;
  } step_result_t;

  // register copies
  logic [W_BITS-1:0]      weight;
  logic [SETTLE_BITS-1:0] settle_req;
  logic [MARGIN_BITS-1:0] margin;

  // detector state
  logic                   seeded;
  logic [MAG_BITS-1:0]    avg;
  logic [MAG_BITS-1:0]    peak_high;
  logic [MAG_BITS-1:0]    peak_low;
  logic [SETTLE_BITS-1:0] settle_cnt;
  phase_t                 phase;
  logic [STEP_BITS-1:0]   steps;

  step_result_t predicted_results[$];
  int           fail_cnt;

  function automatic logic [MAG_BITS-1:0] floor_root(logic [31:0] v);
    logic [31:0] root;
    logic [31:0] trial;
    root = '0;
    for (int b = MAG_BITS; b >= 0; b--) begin
      trial = root | (32'd1 << b);
      if (trial * trial <= v) root = trial;
    end
    return (root > 32'(MAG_MAX)) ? MAG_MAX : root[MAG_BITS-1:0];
  endfunction

  function automatic void bump_settle();
    if (settle_cnt != SETTLE_SAT) settle_cnt++;
  endfunction

  function automatic step_result_t predict_sample(logic [AXIS_BITS-1:0] x,
                                                  logic [AXIS_BITS-1:0] y,
                                                  logic [AXIS_BITS-1:0] z);
    logic [31:0]         sum;
    logic [31:0]         blend;
    logic [MAG_BITS-1:0] mag;
    int                  lo_thr;
    int                  hi_thr;
    logic                seen;
    step_result_t        r;
    sum  = 32'(x) * 32'(x) + 32'(y) * 32'(y) + 32'(z) * 32'(z);
    mag  = floor_root(sum);
    seen = 1'b0;
    if (!seeded) begin
      // seeding sample, detector left alone
      avg    = mag;
      seeded = 1'b1;
    end else begin
      blend  = 32'(weight) * 32'(mag) + (32'd1023 - 32'(weight)) * 32'(avg);
      avg    = MAG_BITS'(blend >> 10);
      lo_thr = int'(avg) - int'(margin);
      hi_thr = int'(avg) + int'(margin);
      case (phase)
        PH_MAX: begin
          if (mag > peak_high) begin
            peak_high  = mag;
            settle_cnt = '0;
          end else begin
            bump_settle();
            if (settle_cnt >= settle_req) phase = PH_FALL;
          end
        end
        PH_FALL: begin
          if (mag > peak_high) begin
            peak_high  = mag;
            settle_cnt = '0;
            phase      = PH_MAX;
          end else if (int'(mag) < lo_thr) begin
            steps++;
            seen       = 1'b1;
            peak_low   = PEAK_LOW_RESET;
            settle_cnt = '0;
            phase      = PH_MIN;
          end
        end
        PH_MIN: begin
          if (mag < peak_low) begin
            peak_low   = mag;
            settle_cnt = '0;
          end else begin
            bump_settle();
            if (settle_cnt >= settle_req) phase = PH_RISE;
          end
        end
        default: begin
          if (mag < peak_low) begin
            peak_low   = mag;
            settle_cnt = '0;
            phase      = PH_MIN;
          end else if (int'(mag) > hi_thr) begin
            steps++;
            seen       = 1'b1;
            peak_high  = '0;
            settle_cnt = '0;
            phase      = PH_MAX;
          end
        end
      endcase
    end
    r.magnitude      = mag;
    r.average        = avg;
    r.step_total     = steps;
    r.step_seen      = seen;
    r.detector_phase = phase;
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      fail_cnt++;
    end
  endfunction

  always @(posedge clk) begin
    step_result_t want;
    if (rst) begin
      weight     = WEIGHT_RESET;
      settle_req = SETTLE_RESET;
      margin     = MARGIN_RESET;
      seeded     = 1'b0;
      avg        = '0;
      peak_high  = '0;
      peak_low   = PEAK_LOW_RESET;
      settle_cnt = '0;
      phase      = PH_MAX;
      steps      = '0;
      fail_cnt   = 0;
      predicted_results.delete();
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_WEIGHT: weight     = cfg.data[W_BITS-1:0];
          REG_SETTLE: settle_req = cfg.data[SETTLE_BITS-1:0];
          REG_MARGIN: margin     = cfg.data[MARGIN_BITS-1:0];
          default: ;
        endcase
      end
      if (results.valid && results.ready) begin
        if (predicted_results.size() == 0) begin
          $error("result item with none expected, magnitude %0d", results.magnitude);
          fail_cnt++;
        end else begin
          want = predicted_results.pop_front();
          check_field("magnitude", 32'(want.magnitude), 32'(results.magnitude));
          check_field("average", 32'(want.average), 32'(results.average));
          check_field("step_total", want.step_total, results.step_total);
          check_field("step_seen", 32'(want.step_seen), 32'(results.step_seen));
          check_field("detector_phase", 32'(want.detector_phase),
                      32'(results.detector_phase));
        end
      end
      if (samples.valid && samples.ready)
        predicted_results.push_back(predict_sample(samples.accel_x, samples.accel_y,
                                                   samples.accel_z));
    end
    fails   <= fail_cnt;
    pending <= predicted_results.size();
  end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import asd_pkg::*;

  // cycles with no handshake at all before the run is called hung
  localparam int IDLE_LIMIT  = 2000;
  // a little more than one item's worth of cycles inside the block
  localparam int TAIL_CYCLES = 40;
  // index with no register behind it
  localparam logic [CFG_IDX_BITS-1:0] REG_NONE = 2'd3;
  localparam logic [AXIS_BITS-1:0]    AXIS_TOP = '1;

  logic clk = 1'b0;
  logic rst;
  bit   calm = 1'b0;   // when set, neither side idles
  int   fail_total;
  int   pending_items;
  int   idle_cycles = 0;

  asd_sample_if samples_ch ();
  asd_result_if results_ch ();
  asd_cfg_if    cfg_ch ();

  always #4 clk = ~clk;

  accel_step_detector dut (
    .clk     (clk),
    .rst     (rst),
    .samples (samples_ch),
    .results (results_ch),
    .cfg     (cfg_ch)
  );

  step_predict_check u_check (
    .clk     (clk),
    .rst     (rst),
    .samples (samples_ch),
    .results (results_ch),
    .cfg     (cfg_ch),
    .fails   (fail_total),
    .pending (pending_items)
  );

  // result side back-pressure, ready low about 12 percent of the time
  always @(posedge clk) begin
    if (rst) begin
      results_ch.ready <= 1'b0;
    end else begin
      results_ch.ready <= calm || ($urandom_range(0, 99) >= 12);
    end
  end

  // watchdog: any accepted item on any channel restarts the count
  always @(posedge clk) begin
    if (rst || (samples_ch.valid && samples_ch.ready) ||
        (results_ch.valid && results_ch.ready) || (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // one sample item; valid is left high so back-to-back items need no gap
  task automatic send_sample(input logic [AXIS_BITS-1:0] x, input logic [AXIS_BITS-1:0] y,
                             input logic [AXIS_BITS-1:0] z);
    while (!calm && $urandom_range(0, 99) < 12) begin
      samples_ch.valid <= 1'b0;
      @(posedge clk);
    end
    samples_ch.valid   <= 1'b1;
    samples_ch.accel_x <= x;
    samples_ch.accel_y <= y;
    samples_ch.accel_z <= z;
    do @(posedge clk); while (!samples_ch.ready);
  endtask

  // stop sending and wait until every predicted result has come back
  task automatic drain();
    samples_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_items != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
  endtask

  // registers only change with the block idle
  task automatic apply_setting(input logic [CFG_DATA_BITS-1:0] w,
                               input logic [CFG_DATA_BITS-1:0] s,
                               input logic [CFG_DATA_BITS-1:0] m);
    drain();
    write_reg(REG_WEIGHT, w);
    write_reg(REG_SETTLE, s);
    write_reg(REG_MARGIN, m);
    cfg_ch.valid <= 1'b0;
  endtask

  // turn a wanted magnitude into axes: either one dominant axis or an even split
  task automatic send_magnitude(input int target, input int jitter);
    int ax[3];
    int share;
    int pick;
    if (target > 1772) target = 1772;
    if (target < 0) target = 0;
    if (target <= 1023 && (jitter == 0 || $urandom_range(0, 2) == 0)) begin
      pick = $urandom_range(0, 2);
      for (int k = 0; k < 3; k++) ax[k] = (k == pick) ? target : $urandom_range(0, jitter);
    end else begin
      share = (target * 591) >> 10;
      for (int k = 0; k < 3; k++) begin
        ax[k] = share + int'($urandom_range(0, 2 * jitter)) - jitter;
        if (ax[k] < 0) ax[k] = 0;
        if (ax[k] > 1023) ax[k] = 1023;
      end
    end
    send_sample(AXIS_BITS'(ax[0]), AXIS_BITS'(ax[1]), AXIS_BITS'(ax[2]));
  endtask

  // step-like walk: plateaus alternating between a high and a low band,
  // with jitter on the plateau and a share of raw noise items mixed in
  task automatic run_walk(input int count, input int lvl_lo, input int lvl_hi,
                          input int hold_lo, input int hold_hi, input int jitter,
                          input int noise_pct);
    int left;
    int level;
    int mid;
    bit up;
    mid  = (lvl_lo + lvl_hi) / 2;
    up   = 1'b0;
    left = 0;
    for (int i = 0; i < count; i++) begin
      if (left == 0) begin
        up    = !up;
        level = up ? $urandom_range(mid, lvl_hi) : $urandom_range(lvl_lo, mid);
        left  = $urandom_range(hold_lo, hold_hi);
      end
      left--;
      if ($urandom_range(0, 99) < noise_pct) begin
        send_sample(AXIS_BITS'($urandom), AXIS_BITS'($urandom), AXIS_BITS'($urandom));
      end else begin
        send_magnitude(level + int'($urandom_range(0, 2 * jitter)) - jitter, jitter);
      end
      // now and then hold off until the block has emptied
      if ($urandom_range(0, 99) < 2) drain();
    end
  endtask

  initial begin
    rst                = 1'b1;
    samples_ch.valid   = 1'b0;
    samples_ch.accel_x = '0;
    samples_ch.accel_y = '0;
    samples_ch.accel_z = '0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.index       = REG_WEIGHT;
    cfg_ch.data        = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed part at reset register values
    send_sample('0, '0, '0);                   // seeding sample, zero magnitude
    send_sample(AXIS_TOP, AXIS_TOP, AXIS_TOP); // largest magnitude
    send_sample(AXIS_TOP, '0, '0);
    send_sample('0, AXIS_TOP, '0);
    send_sample('0, '0, AXIS_TOP);
    send_sample(10'd1, 10'd1, 10'd1);
    repeat (6) send_sample(10'd700, 10'd700, 10'd700);  // plateau, peak gets confirmed
    repeat (4) send_sample(10'd20, 10'd20, 10'd20);     // drop below the average

    // write to an index with no register, then a settle value with bits above its width
    drain();
    write_reg(REG_NONE, '1);
    write_reg(REG_SETTLE, 10'h300);  // masks to zero settle samples
    cfg_ch.valid <= 1'b0;
    repeat (2) begin
      send_sample(10'd900, 10'd900, 10'd900);
      send_sample(10'd5, 10'd5, 10'd5);
    end

    // random walks over a spread of settings
    apply_setting(10'd128, 10'd5, 10'd25);
    run_walk(70, 50, 1500, 6, 14, 15, 8);

    // long stretch with no idling on either side
    apply_setting(10'd1023, 10'd1, 10'd0);
    calm <= 1'b1;
    run_walk(80, 0, 1772, 2, 8, 10, 8);
    calm <= 1'b0;

    // margin so wide that the lower threshold goes negative
    apply_setting(10'd0, 10'd3, 10'd1023);
    run_walk(60, 0, 1772, 3, 10, 10, 8);

    apply_setting(10'd512, 10'h300, 10'd10);
    run_walk(80, 0, 1200, 1, 6, 20, 10);

    repeat (2) begin
      apply_setting(CFG_DATA_BITS'($urandom_range(0, 1023)),
                    CFG_DATA_BITS'($urandom_range(1, 12)),
                    CFG_DATA_BITS'($urandom_range(0, 120)));
      run_walk(60, $urandom_range(0, 300), $urandom_range(900, 1772), 2, 20, 20, 10);
    end

    // largest settle count: clean plateaus long enough to saturate the counter
    apply_setting(10'd64, 10'd255, 10'd5);
    run_walk(270, 100, 1000, 262, 266, 0, 0);

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_total == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
